/* hw/rtl/sti_pkg.sv */
// Package for the sorted table insert block: field widths, status and
// policy codes, controller states and the command struct broadcast to the cells.
// No dependencies.
package sti_pkg;

  // Field widths of the item on either channel.
  localparam int unsigned KeyBits     = 32;
  localparam int unsigned PayloadIn   = 32;
  localparam int unsigned PolicyBits  = 2;
  localparam int unsigned SlotBits    = 6;
  localparam int unsigned StatusBits  = 3;
  localparam int unsigned TotalBits   = 7;
  localparam int unsigned InDataBits  = 72;
  localparam int unsigned OutDataBits = 16;

  // Duplicate handling requested with an item.
  typedef enum logic [PolicyBits-1:0] {
    POL_REPLACE = 2'd0,
    POL_KEEP    = 2'd1,
    POL_DUP     = 2'd2,
    POL_BAD     = 2'd3
  } policy_e;

  // Outcome reported with each result item.
  typedef enum logic [StatusBits-1:0] {
    ST_NEW      = 3'd0,
    ST_REPLACED = 3'd1,
    ST_KEPT     = 3'd2,
    ST_DUP      = 3'd3,
    ST_BADPOL   = 3'd4,
    ST_FULL     = 3'd5
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_PROBE,
    S_DECIDE
  } state_e;

  // Command broadcast from the controller to every cell.
  typedef struct packed {
    logic cmp;  // register the compare flags against the new key
    logic ins;  // splice the new entry in at the target index
    logic rep;  // overwrite the entry at the target index
  } cell_cmd_t;

endpackage

/* hw/rtl/sorted_table_insert.sv */
// Sorted table insert: keeps up to TABLE_DEPTH key and payload entries in
// ascending signed key order in a row of cells, each holding one entry.
//
// Input channel s_axis: one item per request carries key, payload and the
// duplicate policy. Output channel m_axis: one item per request carries the
// slot index, the status and the entry count after the request.
// After an input item is accepted, the controller samples the compare flags
// of all cells, then the binary search takes one probe per cycle (at most
// log2(TABLE_DEPTH)+1 probes, seven at depth 64), and the decision state
// applies the outcome; an insert shifts every entry above the slot up by one
// cell. The result item is registered by the decision, and the next input
// item is taken once the controller is back in idle; on an empty table the
// search is skipped.
// The next input item is taken as soon as the result is registered, even if
// the receiver has not yet claimed it; a stalled receiver holds the block in
// its decision cycle only when a second result is ready.
// Reset empties the table at once: the entry count clears, the cell contents
// are left as they are and are never read before they are written.
module sorted_table_insert
  import sti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH  = 64,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [31:0] key (signed), [63:32] payload, [65:64] dup_policy, [71:66] zero
  input  logic [InDataBits-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [5:0] slot_index, [8:6] status, [15:9] entry_total
  output logic [OutDataBits-1:0] m_axis_tdata
);

  localparam int unsigned IdxBits = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CntBits = $clog2(TABLE_DEPTH + 1);

  logic [KeyBits-1:0]      req_key_q;
  logic [PAYLOAD_BITS-1:0] req_pay_q;
  logic [PAYLOAD_BITS-1:0] in_pay;
  logic                    accept;

  cell_cmd_t               cmd;
  logic [IdxBits-1:0]      pos;
  logic [TABLE_DEPTH-1:0]  lt_vec;
  logic [TABLE_DEPTH-1:0]  eq_vec;
  logic [KeyBits-1:0]      cell_key [TABLE_DEPTH];
  logic [PAYLOAD_BITS-1:0] cell_pay [TABLE_DEPTH];

  logic [SlotBits-1:0]     slot;
  logic [StatusBits-1:0]   status;
  logic [TotalBits-1:0]    total;

  assign accept = s_axis_tvalid && s_axis_tready;
  assign in_pay = PAYLOAD_BITS'({32'd0, s_axis_tdata[63:32]});

  // Request register: key and payload stay put while the item is processed.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_key_q <= s_axis_tdata[31:0];
      req_pay_q <= in_pay;
    end
  end

  sti_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .IDX_BITS    (IdxBits),
    .CNT_BITS    (CntBits)
  ) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .pol_i     (s_axis_tdata[65:64]),
    .lt_i      (lt_vec),
    .eq_i      (eq_vec),
    .cmd_o     (cmd),
    .pos_o     (pos),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .slot_o    (slot),
    .status_o  (status),
    .total_o   (total)
  );

  // Row of cells; on an insert each cell above the target takes its lower neighbor's entry.
  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic [KeyBits-1:0]      prev_key;
    logic [PAYLOAD_BITS-1:0] prev_pay;
    if (i == 0) begin : g_first
      assign prev_key = req_key_q;
      assign prev_pay = req_pay_q;
    end else begin : g_rest
      assign prev_key = cell_key[i-1];
      assign prev_pay = cell_pay[i-1];
    end
    sti_cell #(
      .INDEX    (i),
      .IDX_BITS (IdxBits),
      .PAY_BITS (PAYLOAD_BITS)
    ) u_cell (
      .clk_i      (clk_i),
      .cmd_i      (cmd),
      .pos_i      (pos),
      .new_key_i  (req_key_q),
      .new_pay_i  (req_pay_q),
      .prev_key_i (prev_key),
      .prev_pay_i (prev_pay),
      .key_o      (cell_key[i]),
      .pay_o      (cell_pay[i]),
      .lt_o       (lt_vec[i]),
      .eq_o       (eq_vec[i])
    );
  end

  assign m_axis_tdata = {total, status, slot};

endmodule

/* hw/rtl/sti_cell.sv */
// One table cell: holds a key and payload, compares its key with the new key,
// and takes its lower neighbor's entry when an insert shifts the row up.
// Depends on sti_pkg.
module sti_cell
  import sti_pkg::*;
#(
  parameter int unsigned INDEX    = 0,
  parameter int unsigned IDX_BITS = 6,
  parameter int unsigned PAY_BITS = 32
) (
  input  logic                clk_i,
  input  cell_cmd_t           cmd_i,
  input  logic [IDX_BITS-1:0] pos_i,
  input  logic [KeyBits-1:0]  new_key_i,
  input  logic [PAY_BITS-1:0] new_pay_i,
  input  logic [KeyBits-1:0]  prev_key_i,
  input  logic [PAY_BITS-1:0] prev_pay_i,
  output logic [KeyBits-1:0]  key_o,
  output logic [PAY_BITS-1:0] pay_o,
  output logic                lt_o,
  output logic                eq_o
);

  localparam logic [IDX_BITS-1:0] MyIdx = IDX_BITS'(INDEX);

  logic [KeyBits-1:0]  key_q, key_d;
  logic [PAY_BITS-1:0] pay_q, pay_d;
  logic                lt_q, lt_d;
  logic                eq_q, eq_d;

  // Entry update: load the new entry at the target, shift above it on insert.
  always_comb begin
    key_d = key_q;
    pay_d = pay_q;
    if ((cmd_i.ins || cmd_i.rep) && (pos_i == MyIdx)) begin
      key_d = new_key_i;
      pay_d = new_pay_i;
    end else if (cmd_i.ins && (pos_i < MyIdx)) begin
      key_d = prev_key_i;
      pay_d = prev_pay_i;
    end
  end

  // Signed compare flags, sampled once per item for the search.
  always_comb begin
    lt_d = lt_q;
    eq_d = eq_q;
    if (cmd_i.cmp) begin
      lt_d = $signed(key_q) < $signed(new_key_i);
      eq_d = key_q == new_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    pay_q <= pay_d;
    lt_q  <= lt_d;
    eq_q  <= eq_d;
  end

  assign key_o = key_q;
  assign pay_o = pay_q;
  assign lt_o  = lt_q;
  assign eq_o  = eq_q;

endmodule

/* hw/rtl/sti_ctrl.sv */
// Controller: runs the binary search over the cells' compare flags, picks the
// outcome, commands the cells, keeps the entry count and holds the result item.
// Depends on sti_pkg.
module sti_ctrl
  import sti_pkg::*;
#(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned IDX_BITS    = 6,
  parameter int unsigned CNT_BITS    = 7
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_valid_i,
  output logic                   s_ready_o,
  input  logic [PolicyBits-1:0]  pol_i,
  input  logic [TABLE_DEPTH-1:0] lt_i,
  input  logic [TABLE_DEPTH-1:0] eq_i,
  output cell_cmd_t              cmd_o,
  output logic [IDX_BITS-1:0]    pos_o,
  output logic                   m_valid_o,
  input  logic                   m_ready_i,
  output logic [SlotBits-1:0]    slot_o,
  output logic [StatusBits-1:0]  status_o,
  output logic [TotalBits-1:0]   total_o
);

  localparam logic [CNT_BITS-1:0] Depth = CNT_BITS'(TABLE_DEPTH);

  state_e              state_q, state_d;
  logic [CNT_BITS-1:0] lo_q, lo_d, hi_q, hi_d;
  logic [CNT_BITS-1:0] count_q, count_d;
  logic [IDX_BITS-1:0] mid_q, mid_d;
  logic                found_q, found_d;
  policy_e             pol_q, pol_d;
  logic                m_valid_q, m_valid_d;
  logic [SlotBits-1:0] slot_q, slot_d;
  status_e             status_q, status_d;
  logic [TotalBits-1:0] total_q, total_d;

  logic [CNT_BITS:0]   sum;
  logic [IDX_BITS-1:0] probe;
  logic                full;
  logic [IDX_BITS-1:0] res_idx;
  status_e             res_st;
  logic                res_ins;
  logic                res_rep;

  assign sum   = {1'b0, lo_q} + {1'b0, hi_q};
  assign probe = IDX_BITS'(sum >> 1);
  assign full  = count_q == Depth;

  // Outcome of a finished search.
  always_comb begin
    res_idx = '0;
    res_st  = ST_NEW;
    res_ins = 1'b0;
    res_rep = 1'b0;
    if (!found_q) begin
      if (full) begin
        res_st = ST_FULL;
      end else begin
        res_idx = IDX_BITS'(lo_q);
        res_ins = 1'b1;
      end
    end else begin
      unique case (pol_q)
        POL_REPLACE: begin
          res_idx = mid_q;
          res_st  = ST_REPLACED;
          res_rep = 1'b1;
        end
        POL_KEEP: begin
          res_idx = mid_q;
          res_st  = ST_KEPT;
        end
        POL_DUP: begin
          if (full) begin
            res_st = ST_FULL;
          end else begin
            res_idx = mid_q;
            res_st  = ST_DUP;
            res_ins = 1'b1;
          end
        end
        default: begin
          res_st = ST_BADPOL;
        end
      endcase
    end
  end

  // Next state, search bounds and result register.
  always_comb begin
    state_d   = state_q;
    lo_d      = lo_q;
    hi_d      = hi_q;
    mid_d     = mid_q;
    found_d   = found_q;
    pol_d     = pol_q;
    count_d   = count_q;
    m_valid_d = m_valid_q && !m_ready_i;
    slot_d    = slot_q;
    status_d  = status_q;
    total_d   = total_q;
    cmd_o     = '0;
    pos_o     = res_idx;
    s_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        s_ready_o = 1'b1;
        if (s_valid_i) begin
          pol_d   = policy_e'(pol_i);
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        cmd_o.cmp = 1'b1;
        lo_d      = '0;
        hi_d      = count_q;
        found_d   = 1'b0;
        state_d   = (count_q == '0) ? S_DECIDE : S_PROBE;
      end
      S_PROBE: begin
        if (lt_i[probe]) begin
          lo_d = CNT_BITS'(probe) + CNT_BITS'(1);
        end else if (eq_i[probe]) begin
          found_d = 1'b1;
          mid_d   = probe;
        end else begin
          hi_d = CNT_BITS'(probe);
        end
        if (found_d || (lo_d >= hi_d)) begin
          state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        // Wait here only while the previous result is still unclaimed.
        if (!m_valid_q || m_ready_i) begin
          cmd_o.ins = res_ins;
          cmd_o.rep = res_rep;
          if (res_ins) begin
            count_d = count_q + CNT_BITS'(1);
          end
          m_valid_d = 1'b1;
          slot_d    = SlotBits'(res_idx);
          status_d  = res_st;
          total_d   = TotalBits'(count_d);
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q     <= lo_d;
    hi_q     <= hi_d;
    mid_q    <= mid_d;
    found_q  <= found_d;
    pol_q    <= pol_d;
    slot_q   <= slot_d;
    status_q <= status_d;
    total_q  <= total_d;
  end

  assign m_valid_o = m_valid_q;
  assign slot_o    = slot_q;
  assign status_o  = status_q;
  assign total_o   = total_q;

`ifndef SYNTHESIS
  // The table never holds more entries than it has cells.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= Depth)
    else $error("entry count above table depth");

  // The count moves only when a decision is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_DECIDE) |=> (count_q == $past(count_q)))
    else $error("entry count changed outside a decision");

  // Every probe lies inside a non-empty search window.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_PROBE) |-> (lo_q < hi_q) && (hi_q <= count_q))
    else $error("probe with an empty or oversized window");

  // A rejected item reports index zero.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && ((status_q == ST_FULL) || (status_q == ST_BADPOL)) |-> (slot_q == '0))
    else $error("rejected item with a nonzero index");
`endif

endmodule
